[rtl/core/ash_pkg.sv]
`default_nettype none

package ash_pkg;

    // default sizes
    localparam int STREAMS_DEF    = 64;
    localparam int BINS_DEF       = 64;
    localparam int COUNT_BITS_DEF = 32;

    // fixed field widths
    localparam int OP_W          = 2;
    localparam int STREAM_W      = 8;
    localparam int ADDR_W        = 64;
    localparam int SIZE_W        = 16;
    localparam int BIN_IDX_W     = 6;
    localparam int STRIDE_BIN_W  = 6;
    localparam int COUNT_OUT_W   = 32;
    localparam int CFG_W         = 7;

    localparam logic [CFG_W-1:0] STREAMS_IN_USE_RST = 7'd64;

    // op codes
    localparam logic [OP_W-1:0] OP_RECORD    = 2'd0;
    localparam logic [OP_W-1:0] OP_NEW_TRACE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;

    typedef enum logic [1:0] {
        KIND_IGNORE,
        KIND_NEW_TRACE,
        KIND_RECORD,
        KIND_READ
    } ash_kind_t;

    // classified beat, as queued between front and back
    typedef struct packed {
        ash_kind_t                kind;
        logic [STREAM_W-1:0]      stream;
        logic [ADDR_W-1:0]        address;
        logic [SIZE_W-1:0]        size;      // zero already mapped to one
        logic [BIN_IDX_W-1:0]     bin;
        logic                     bin_ok;
    } ash_entry_t;

    typedef struct packed {
        logic       valid;
        ash_entry_t entry;
    } ash_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } ash_qctrl_t;

    typedef struct packed {
        logic                     accepted;
        logic                     stride_counted;
        logic [STRIDE_BIN_W-1:0]  stride_bin;
        logic [COUNT_OUT_W-1:0]   bin_count;
        logic                     histogram_present;
    } ash_result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DIFF,
        ST_RANGE,
        ST_DIV,
        ST_CNT_RD,
        ST_CNT_UPD,
        ST_DONE
    } ash_state_t;

endpackage

`default_nettype wire

[rtl/core/ash_item_if.sv]
`default_nettype none

interface ash_item_if;
    logic                            valid;
    logic                            ready;
    logic [ash_pkg::OP_W-1:0]        op;
    logic [ash_pkg::STREAM_W-1:0]    stream_index;
    logic [ash_pkg::ADDR_W-1:0]      address;
    logic [ash_pkg::SIZE_W-1:0]      access_size;
    logic [ash_pkg::BIN_IDX_W-1:0]   bin_index;

    modport source (
        output valid, op, stream_index, address, access_size, bin_index,
        input  ready
    );
    modport sink (
        input  valid, op, stream_index, address, access_size, bin_index,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/ash_result_if.sv]
`default_nettype none

interface ash_result_if;
    logic                              valid;
    logic                              ready;
    logic                              accepted;
    logic                              stride_counted;
    logic [ash_pkg::STRIDE_BIN_W-1:0]  stride_bin;
    logic [ash_pkg::COUNT_OUT_W-1:0]   bin_count;
    logic                              histogram_present;

    modport source (
        output valid, accepted, stride_counted, stride_bin, bin_count, histogram_present,
        input  ready
    );
    modport sink (
        input  valid, accepted, stride_counted, stride_bin, bin_count, histogram_present,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/ash_front.sv]
`default_nettype none

module ash_front #(
    parameter int STREAMS = ash_pkg::STREAMS_DEF,
    parameter int BINS    = ash_pkg::BINS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ash_pkg::CFG_W-1:0]   cfg_wdata,
    ash_item_if.sink                         item,
    output ash_pkg::ash_head_t               head,
    input  wire ash_pkg::ash_qctrl_t         qctrl
);

    logic [ash_pkg::CFG_W-1:0] streams_in_use_reg;
    logic [ash_pkg::CFG_W-1:0] streams_in_use_next;

    // two-entry queue
    ash_pkg::ash_entry_t ent_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;

    ash_pkg::ash_entry_t cls;
    logic                in_range;
    logic                push;

    // classify the incoming beat
    always_comb begin
        in_range = ({1'b0, item.stream_index} < {2'b0, streams_in_use_reg})
                && (32'(item.stream_index) < 32'(STREAMS));
        cls.stream  = item.stream_index;
        cls.address = item.address;
        cls.size    = (item.access_size == '0) ? ash_pkg::SIZE_W'(1) : item.access_size;
        cls.bin     = item.bin_index;
        cls.bin_ok  = 32'(item.bin_index) < 32'(BINS);
        unique case (item.op)
            ash_pkg::OP_NEW_TRACE: cls.kind = ash_pkg::KIND_NEW_TRACE;
            ash_pkg::OP_RECORD:    cls.kind = in_range ? ash_pkg::KIND_RECORD
                                                       : ash_pkg::KIND_IGNORE;
            ash_pkg::OP_READ:      cls.kind = in_range ? ash_pkg::KIND_READ
                                                       : ash_pkg::KIND_IGNORE;
            default:               cls.kind = ash_pkg::KIND_IGNORE;
        endcase
    end

    assign item.ready = (count_reg != 2'd2) && !qctrl.clearing;
    assign push       = item.valid && item.ready;

    assign head.valid = count_reg != 2'd0;
    assign head.entry = ent_reg[rd_ptr_reg];

    always_comb begin
        streams_in_use_next = cfg_we ? cfg_wdata : streams_in_use_reg;
        wr_ptr_next         = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next         = qctrl.pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next          = count_reg + {1'b0, push} - {1'b0, qctrl.pop};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            streams_in_use_reg <= ash_pkg::STREAMS_IN_USE_RST;
            wr_ptr_reg         <= 1'b0;
            rd_ptr_reg         <= 1'b0;
            count_reg          <= 2'd0;
        end
        else
        begin
            streams_in_use_reg <= streams_in_use_next;
            wr_ptr_reg         <= wr_ptr_next;
            rd_ptr_reg         <= rd_ptr_next;
            count_reg          <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ash_back.sv]
`default_nettype none

module ash_back #(
    parameter int STREAMS    = ash_pkg::STREAMS_DEF,
    parameter int BINS       = ash_pkg::BINS_DEF,
    parameter int COUNT_BITS = ash_pkg::COUNT_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ash_pkg::ash_head_t head,
    output ash_pkg::ash_qctrl_t     qctrl,
    ash_result_if.source            result
);

    localparam int SW    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int QB    = $clog2(BINS);
    localparam int QBW   = (QB > 1) ? $clog2(QB) : 1;
    localparam int RW    = ash_pkg::SIZE_W + QB;
    localparam int DEPTH = STREAMS * BINS;
    localparam int CAW   = $clog2(DEPTH);
    localparam int CB    = COUNT_BITS;
    localparam int AW    = ash_pkg::ADDR_W;
    localparam int OW    = ash_pkg::COUNT_OUT_W;
    localparam int SBW   = ash_pkg::STRIDE_BIN_W;

    // storage
    logic [AW-1:0] la_mem  [STREAMS];
    logic [CB-1:0] cnt_mem [DEPTH];
    logic [AW-1:0] la_rd_reg;
    logic [CB-1:0] cnt_rd_reg;

    ash_pkg::ash_state_t  state_reg, state_next;
    ash_pkg::ash_entry_t  cur_reg, cur_next;
    logic [AW-1:0]        diff_reg, diff_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [QBW-1:0]       step_reg, step_next;
    logic [QB-1:0]        bin_reg, bin_next;
    ash_pkg::ash_result_t res_reg, res_next;
    ash_pkg::ash_result_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CAW-1:0]       clr_reg, clr_next;
    logic [STREAMS-1:0]   last_valid_reg, last_valid_next;
    logic [STREAMS-1:0]   hist_reg, hist_next;

    // fsm strobes
    logic ctl_pop, la_we, cnt_we, out_load, clearing;

    // datapath
    logic [SW-1:0]     cur_s;
    logic [QB-1:0]     bin_cl;
    logic [CAW-1:0]    cnt_addr, cnt_waddr;
    logic [CB-1:0]     cnt_inc, cnt_wdata;
    logic [CB+OW-1:0]  cnt_ext;
    logic [OW-1:0]     count_out;
    logic [QB+SBW-1:0] bin_ext;
    logic [QB+ash_pkg::BIN_IDX_W-1:0] rbin_ext;
    logic [AW-1:0]     size_sh;
    logic              over;
    logic [RW-1:0]     div_sub;
    logic [RW:0]       trial;

    always_comb begin
        cur_s     = cur_reg.stream[SW-1:0];
        bin_cl    = ((QB+1)'(bin_reg) >= (QB+1)'(BINS)) ? QB'(BINS - 1) : bin_reg;
        cnt_addr  = CAW'(cur_s) * CAW'(BINS) + CAW'(bin_cl);
        cnt_inc   = (&cnt_rd_reg) ? cnt_rd_reg : cnt_rd_reg + CB'(1);
        cnt_ext   = {{OW{1'b0}}, cnt_rd_reg};
        count_out = (|cnt_ext[CB+OW-1:OW]) ? {OW{1'b1}} : cnt_ext[OW-1:0];
        bin_ext   = {{SBW{1'b0}}, bin_cl};
        rbin_ext  = {{QB{1'b0}}, head.entry.bin};
        size_sh   = AW'(cur_reg.size) << QB;
        over      = diff_reg >= size_sh;
        div_sub   = RW'(cur_reg.size) << step_reg;
        trial     = {1'b0, rem_reg} - {1'b0, div_sub};
        cnt_waddr = clearing ? clr_reg : cnt_addr;
        cnt_wdata = clearing ? '0 : cnt_inc;
    end

    // fsm outputs
    always_comb begin
        ctl_pop  = 1'b0;
        la_we    = 1'b0;
        cnt_we   = 1'b0;
        out_load = 1'b0;
        clearing = 1'b0;
        unique case (state_reg)
            ash_pkg::ST_CLEAR:
            begin
                clearing = 1'b1;
                cnt_we   = 1'b1;
            end
            ash_pkg::ST_IDLE:    ctl_pop  = head.valid;
            ash_pkg::ST_LOAD:    la_we    = 1'b1;
            ash_pkg::ST_CNT_UPD: cnt_we   = cur_reg.kind == ash_pkg::KIND_RECORD;
            ash_pkg::ST_DONE:    out_load = !out_valid_reg || result.ready;
            default: ;
        endcase
    end

    // fsm next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ash_pkg::ST_CLEAR:
                if (clr_reg == CAW'(DEPTH - 1))
                begin
                    state_next = ash_pkg::ST_IDLE;
                end
            ash_pkg::ST_IDLE:
                if (head.valid)
                begin
                    unique case (head.entry.kind)
                        ash_pkg::KIND_RECORD: state_next = ash_pkg::ST_LOAD;
                        ash_pkg::KIND_READ:   state_next = ash_pkg::ST_CNT_RD;
                        default:              state_next = ash_pkg::ST_DONE;
                    endcase
                end
            ash_pkg::ST_LOAD:
                state_next = last_valid_reg[cur_s] ? ash_pkg::ST_DIFF : ash_pkg::ST_DONE;
            ash_pkg::ST_DIFF:    state_next = ash_pkg::ST_RANGE;
            ash_pkg::ST_RANGE:
                state_next = over ? ash_pkg::ST_CNT_RD : ash_pkg::ST_DIV;
            ash_pkg::ST_DIV:
                if (step_reg == '0)
                begin
                    state_next = ash_pkg::ST_CNT_RD;
                end
            ash_pkg::ST_CNT_RD:  state_next = ash_pkg::ST_CNT_UPD;
            ash_pkg::ST_CNT_UPD: state_next = ash_pkg::ST_DONE;
            ash_pkg::ST_DONE:
                if (out_load)
                begin
                    state_next = ash_pkg::ST_IDLE;
                end
            default: state_next = ash_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        cur_next        = cur_reg;
        diff_next       = diff_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        bin_next        = bin_reg;
        res_next        = res_reg;
        clr_next        = clr_reg;
        last_valid_next = last_valid_reg;
        hist_next       = hist_reg;
        unique case (state_reg)
            ash_pkg::ST_CLEAR: clr_next = clr_reg + CAW'(1);
            ash_pkg::ST_IDLE:
                if (head.valid)
                begin
                    cur_next = head.entry;
                    bin_next = rbin_ext[QB-1:0];
                    res_next = '0;
                    if (head.entry.kind == ash_pkg::KIND_NEW_TRACE)
                    begin
                        last_valid_next = '0;
                    end
                end
            ash_pkg::ST_LOAD:
            begin
                // first access of a stream leaves its result here
                last_valid_next[cur_s]     = 1'b1;
                res_next.accepted          = 1'b1;
                res_next.histogram_present = hist_reg[cur_s];
            end
            ash_pkg::ST_DIFF: diff_next = cur_reg.address - la_rd_reg;
            ash_pkg::ST_RANGE:
            begin
                rem_next  = diff_reg[RW-1:0];
                step_next = QBW'(QB - 1);
                bin_next  = over ? QB'(BINS - 1) : '0;
            end
            ash_pkg::ST_DIV:
            begin
                if (!trial[RW])
                begin
                    rem_next = trial[RW-1:0];
                    bin_next = bin_reg | (QB'(1) << step_reg);
                end
                step_next = step_reg - QBW'(1);
            end
            ash_pkg::ST_CNT_UPD:
            begin
                res_next.accepted = 1'b1;
                if (cur_reg.kind == ash_pkg::KIND_RECORD)
                begin
                    res_next.stride_counted    = 1'b1;
                    res_next.stride_bin        = bin_ext[SBW-1:0];
                    res_next.histogram_present = 1'b1;
                    hist_next[cur_s]           = 1'b1;
                end
                else
                begin
                    res_next.bin_count         = cur_reg.bin_ok ? count_out : '0;
                    res_next.histogram_present = hist_reg[cur_s];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        out_next       = out_load ? res_reg : out_reg;
        out_valid_next = out_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg      <= ash_pkg::ST_CLEAR;
            clr_reg        <= '0;
            last_valid_reg <= '0;
            hist_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            last_valid_reg <= last_valid_next;
            hist_reg       <= hist_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        cur_reg  <= cur_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        bin_reg  <= bin_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // last address per stream
    always_ff @(posedge clk) begin
        if (la_we)
        begin
            la_mem[cur_s] <= cur_reg.address;
        end
        la_rd_reg <= la_mem[cur_s];
    end

    // bin counters
    always_ff @(posedge clk) begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_addr];
    end

    assign qctrl.pop      = ctl_pop;
    assign qctrl.clearing = clearing;

    assign result.valid             = out_valid_reg;
    assign result.accepted          = out_reg.accepted;
    assign result.stride_counted    = out_reg.stride_counted;
    assign result.stride_bin        = out_reg.stride_bin;
    assign result.bin_count         = out_reg.bin_count;
    assign result.histogram_present = out_reg.histogram_present;

endmodule

`default_nettype wire

[rtl/core/access_stride_histogram_top.sv]
// Paths: ignored beats and new trace go straight to the output register; bin reads
//   read the counter RAM; first access of a stream only stores its address; strides
//   past the last bin skip the divide, other strides divide before the counter update.
// The back end holds one beat at a time; the bit-per-cycle divide and the counter
//   read-modify-write set how long each beat takes. Reset: asynchronous, active low;
//   all STREAMS*BINS counters are then swept to zero and no beat is taken until then.
`default_nettype none

module access_stride_histogram_top #(
    parameter int STREAMS    = ash_pkg::STREAMS_DEF,
    parameter int BINS       = ash_pkg::BINS_DEF,
    parameter int COUNT_BITS = ash_pkg::COUNT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ash_pkg::CFG_W-1:0]   cfg_wdata,
    ash_item_if.sink                         item,
    ash_result_if.source                     result
);

    // Front end: holds streams_in_use, classifies each beat (ignored,
    // new trace, record, read), maps size 0 to 1 and queues it (2 deep).
    // Back end: per-stream last address RAM, stride divide (quotient past the
    // top bin clamped to it without dividing, else one quotient bit per cycle),
    // saturating bin counter RAM and an output register, so the queue keeps
    // filling while a result waits downstream.

    ash_pkg::ash_head_t  head;
    ash_pkg::ash_qctrl_t qctrl;

    ash_front #(
        .STREAMS (STREAMS),
        .BINS    (BINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .head      (head),
        .qctrl     (qctrl)
    );

    ash_back #(
        .STREAMS    (STREAMS),
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qctrl  (qctrl),
        .result (result)
    );

endmodule

`default_nettype wire
